/* sv/wpd_pkg.sv */
// Shared types, constants and helpers for the weighted pressure diffusion stencil.
package wpd_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int RW_W      = 10;
    localparam int MQ_DEPTH  = 4;
    localparam int MQ_AW     = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH  = 8;
    localparam int OQ_AW     = $clog2(OQ_DEPTH);

    localparam logic [15:0]     FLOW_ONE    = 16'd32768;
    localparam logic [RW_W-1:0] WIDTH_RESET = RW_W'(MAX_WIDTH);

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pres_in;
        logic        [15:0] flow_in;
        logic signed [31:0] dir_x_in;
        logic signed [31:0] dir_y_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pres_out;
        logic signed [31:0] dir_x_out;
        logic signed [31:0] dir_y_out;
        logic               saturated;
        logic               frame_end;
    } t_out_item;

    typedef struct packed {
        logic signed [32:0] d_l;
        logic signed [32:0] d_r;
        logic signed [32:0] d_u;
        logic signed [32:0] d_d;
        logic        [15:0] f_l;
        logic        [15:0] f_r;
        logic        [15:0] f_u;
        logic        [15:0] f_d;
        logic signed [31:0] cp;
        logic        [15:0] cf;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               frame_end;
    } t_work;

    typedef struct packed {
        logic signed [31:0] pres;
        logic        [15:0] flow;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } t_center;

    typedef struct packed {
        logic signed [31:0] pres;
        logic        [15:0] flow;
    } t_upper;

    // {clipped, value}
    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        logic [32:0] r;
        if (v > 40'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -40'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

/* sv/wpd_front.sv */
// Front end: line stores, column tracking and neighbor selection.
module wpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [9:0]       i_cfg_wdata,
    input  logic             i_push,
    input  wpd_pkg::t_in_item i_item,
    input  logic             i_q_full,
    output logic             o_q_push,
    output wpd_pkg::t_work   o_q_data
);
    import wpd_pkg::*;

    t_center r_cmem [MAX_WIDTH];
    t_upper  r_umem [MAX_WIDTH];

    logic [RW_W-1:0]  r_width;
    logic [COL_W-1:0] r_col, n_col;
    logic [1:0]       r_rows, n_rows;
    t_center          r_c0, r_c1;
    t_upper           r_u0, r_um;

    logic [RW_W-1:0]  w_eff;
    logic             last, acc, is_data, c_we, u_we;
    t_center          c_wd;
    t_upper           u_wd;
    logic [COL_W-1:0] a_c1, a_um;

    always_comb begin
        if (r_width == '0) begin
            w_eff = RW_W'(1);
        end else if (r_width > RW_W'(MAX_WIDTH)) begin
            w_eff = RW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        last    = ({1'b0, r_col} + RW_W'(1)) >= w_eff;
        acc     = i_push && !i_q_full;
        is_data = (i_item.op == OP_CELL);
        c_we    = acc && is_data;
        u_we    = acc && (is_data || r_rows != 2'd0);
        c_wd    = '{pres: i_item.pres_in, flow: i_item.flow_in,
                    dx: i_item.dir_x_in, dy: i_item.dir_y_in};
        u_wd    = '{pres: r_c0.pres, flow: r_c0.flow};

        n_col  = r_col;
        n_rows = r_rows;
        if (acc) begin
            if (is_data) begin
                if (last) begin
                    n_col = '0;
                    if (r_rows != 2'd2) begin
                        n_rows = r_rows + 2'd1;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else if (r_rows == 2'd0 || last) begin
                n_col  = '0;
                n_rows = 2'd0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        a_c1 = n_col + COL_W'(1);
        a_um = n_col - COL_W'(1);
    end

    always_comb begin
        o_q_push           = acc && (r_rows != 2'd0);
        o_q_data.cp        = r_c0.pres;
        o_q_data.cf        = r_c0.flow;
        o_q_data.dx        = r_c0.dx;
        o_q_data.dy        = r_c0.dy;
        o_q_data.frame_end = !is_data && last;
        if (r_col != '0) begin
            o_q_data.d_l = 33'(r_um.pres) - 33'(r_c0.pres);
            o_q_data.f_l = r_um.flow;
        end else begin
            o_q_data.d_l = -33'(r_c0.pres);
            o_q_data.f_l = FLOW_ONE;
        end
        if (!last) begin
            o_q_data.d_r = 33'(r_c1.pres) - 33'(r_c0.pres);
            o_q_data.f_r = r_c1.flow;
        end else begin
            o_q_data.d_r = -33'(r_c0.pres);
            o_q_data.f_r = FLOW_ONE;
        end
        if (r_rows == 2'd2) begin
            o_q_data.d_u = 33'(r_u0.pres) - 33'(r_c0.pres);
            o_q_data.f_u = r_u0.flow;
        end else begin
            o_q_data.d_u = -33'(r_c0.pres);
            o_q_data.f_u = FLOW_ONE;
        end
        if (is_data) begin
            o_q_data.d_d = 33'(i_item.pres_in) - 33'(r_c0.pres);
            o_q_data.f_d = i_item.flow_in;
        end else begin
            o_q_data.d_d = -33'(r_c0.pres);
            o_q_data.f_d = FLOW_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_col   <= '0;
            r_rows  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            r_col  <= n_col;
            r_rows <= n_rows;
        end
    end

    // line stores, registered reads with same-cycle write bypass
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[r_col] <= c_wd;
        end
        if (u_we) begin
            r_umem[r_col] <= u_wd;
        end
        r_c0 <= (c_we && n_col == r_col) ? c_wd : r_cmem[n_col];
        r_c1 <= (c_we && a_c1 == r_col)  ? c_wd : r_cmem[a_c1];
        r_u0 <= (u_we && n_col == r_col) ? u_wd : r_umem[n_col];
        r_um <= (u_we && a_um == r_col)  ? u_wd : r_umem[a_um];
    end

endmodule

/* sv/wpd_queue.sv */
// Short queue of classified work between front and back.
module wpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wpd_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output wpd_pkg::t_work o_data
);
    import wpd_pkg::*;

    t_work            r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0] r_wp, r_rp;
    logic [MQ_AW:0]   r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == (MQ_AW+1)'(MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + MQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + MQ_AW'(1);
            end
            r_cnt <= r_cnt + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* sv/wpd_back.sv */
// Back end: weighted delta pipeline, rounding, saturation and result queue.
module wpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  wpd_pkg::t_work    i_q_data,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output wpd_pkg::t_out_item o_result
);
    import wpd_pkg::*;

    logic [4:0] r_v;

    // stage 1: neighbor products
    logic signed [49:0] r1_pl, r1_pr, r1_pu, r1_pd;
    logic signed [31:0] r1_cp, r1_dx, r1_dy;
    logic        [15:0] r1_cf;
    logic               r1_fe;
    // stage 2: pair sums split
    logic signed [35:0] r2_hh, r2_vh;
    logic        [14:0] r2_hl, r2_vl;
    logic signed [31:0] r2_cp, r2_dx, r2_dy;
    logic        [15:0] r2_cf;
    logic               r2_fe;
    // stage 3: scaled by center flow
    logic signed [52:0] r3_hm, r3_vm;
    logic        [30:0] r3_hlm, r3_vlm;
    logic signed [31:0] r3_cp, r3_dx, r3_dy;
    logic               r3_fe;
    // stage 4: rounded deltas
    logic signed [38:0] r4_h, r4_v;
    logic signed [31:0] r4_cp, r4_dx, r4_dy;
    logic               r4_fe;
    // stage 5: sums
    logic signed [39:0] r5_s, r5_xs, r5_ys;
    logic signed [31:0] r5_cp;
    logic               r5_fe;

    logic signed [50:0] hp, vp;
    logic signed [53:0] ha, va;
    logic signed [39:0] ps;
    logic [32:0]        sp, sx, sy;
    t_out_item          res;

    t_out_item        r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic [OQ_AW+1:0] used;
    logic             rd;

    always_comb begin
        used    = (OQ_AW+2)'(r_cnt) + (OQ_AW+2)'($countones(r_v));
        o_q_pop = !i_q_empty && (used < (OQ_AW+2)'(OQ_DEPTH));
        hp      = 51'(r1_pl) + 51'(r1_pr);
        vp      = 51'(r1_pu) + 51'(r1_pd);
        ha      = 54'(r3_hm) + 54'sd16384 + $signed({38'd0, r3_hlm[30:15]});
        va      = 54'(r3_vm) + 54'sd16384 + $signed({38'd0, r3_vlm[30:15]});
        ps      = 40'(r5_cp) + (r5_s >>> 2);
        sp      = sat32(ps);
        sx      = sat32(r5_xs);
        sy      = sat32(r5_ys);
        res     = '{pres_out: sp[31:0], dir_x_out: sx[31:0], dir_y_out: sy[31:0],
                    saturated: sp[32] | sx[32] | sy[32], frame_end: r5_fe};
        o_empty  = (r_cnt == '0);
        o_result = r_oq[r_rp];
        rd       = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_v <= {r_v[3:0], o_q_pop};
            if (r_v[4]) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(r_v[4]) - (OQ_AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pl <= i_q_data.d_l * $signed({1'b0, i_q_data.f_l});
        r1_pr <= i_q_data.d_r * $signed({1'b0, i_q_data.f_r});
        r1_pu <= i_q_data.d_u * $signed({1'b0, i_q_data.f_u});
        r1_pd <= i_q_data.d_d * $signed({1'b0, i_q_data.f_d});
        r1_cp <= i_q_data.cp;
        r1_cf <= i_q_data.cf;
        r1_dx <= i_q_data.dx;
        r1_dy <= i_q_data.dy;
        r1_fe <= i_q_data.frame_end;

        r2_hh <= 36'(hp >>> 15);
        r2_vh <= 36'(vp >>> 15);
        r2_hl <= hp[14:0];
        r2_vl <= vp[14:0];
        r2_cp <= r1_cp;
        r2_cf <= r1_cf;
        r2_dx <= r1_dx;
        r2_dy <= r1_dy;
        r2_fe <= r1_fe;

        r3_hm  <= r2_hh * $signed({1'b0, r2_cf});
        r3_vm  <= r2_vh * $signed({1'b0, r2_cf});
        r3_hlm <= r2_hl * r2_cf;
        r3_vlm <= r2_vl * r2_cf;
        r3_cp  <= r2_cp;
        r3_dx  <= r2_dx;
        r3_dy  <= r2_dy;
        r3_fe  <= r2_fe;

        r4_h  <= 39'(ha >>> 15);
        r4_v  <= 39'(va >>> 15);
        r4_cp <= r3_cp;
        r4_dx <= r3_dx;
        r4_dy <= r3_dy;
        r4_fe <= r3_fe;

        r5_s  <= 40'(r4_h) + 40'(r4_v) + 40'sd2;
        r5_xs <= 40'(r4_dx) + 40'(r4_h);
        r5_ys <= 40'(r4_dy) + 40'(r4_v);
        r5_cp <= r4_cp;
        r5_fe <= r4_fe;

        if (r_v[4]) begin
            r_oq[r_wp] <= res;
        end
    end

endmodule

/* sv/weighted_pressure_diffusion_stencil.sv */
// Throughput: one item per cycle while full is low; results drain through an 8-entry queue.
// Neighbors come from two 512-entry line stores read in the cycle before use.
// Reset: synchronous, active low; clears column, row count, queues; row_width 512.
// Line stores are not cleared.
module weighted_pressure_diffusion_stencil (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  wpd_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output wpd_pkg::t_out_item o_result
);
    import wpd_pkg::*;

    logic  q_push, q_full, q_pop, q_empty;
    t_work q_in, q_out;

    assign full = q_full;

    wpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    wpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_out)
    );

    wpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_q_data (q_out),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule
